/* rtl/core/nevs_pkg.sv */
// ---------------------------------------------------------------------------
// nevs_pkg: shared types and constants of the nearest earlier value search
// History depth, index and count widths, and the token that travels the
// cell chain
// ---------------------------------------------------------------------------
package nevs_pkg;

    // number of history cells in the chain
    localparam int HISTORY_DEPTH = 1024;

    // cell index and fill count widths
    localparam int IDX_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);

    // fixed field widths
    localparam int VALUE_W = 32;
    localparam int POS_W   = 11;

    typedef logic [IDX_W-1:0]   t_idx;
    typedef logic [CNT_W-1:0]   t_cnt;
    typedef logic [VALUE_W-1:0] t_value;

    // one query moving down the chain together with its running best
    typedef struct packed {
        logic   valid;
        logic   has_result;
        logic   full;
        logic   wr_en;
        t_idx   wr_idx;
        t_cnt   count;
        t_value x;
        logic   best_ok;
        t_value best_d;
        t_value best_v;
        t_cnt   best_pos;
    } t_token;

endpackage

/* rtl/core/nevs_cell.sv */
// ---------------------------------------------------------------------------
// nevs_cell: one history cell of the search chain
// Holds one stored value, measures the passing query against it and keeps
// the nearer candidate; the query then moves on to the next cell
// ---------------------------------------------------------------------------
module nevs_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  nevs_pkg::t_idx    i_index,
    input  nevs_pkg::t_token  i_tok,
    output nevs_pkg::t_token  o_tok
);

    // stored history value
    nevs_pkg::t_value r_value;

    // distance stage
    nevs_pkg::t_token r_a_tok;
    nevs_pkg::t_value r_a_d;
    nevs_pkg::t_value r_a_v;
    logic             r_a_hit;

    // compare stage
    nevs_pkg::t_token r_b_tok;

    logic                   n_hit;
    logic [nevs_pkg::VALUE_W:0] n_dp;
    logic [nevs_pkg::VALUE_W:0] n_dn;
    nevs_pkg::t_value       n_d;
    logic                   n_take;
    nevs_pkg::t_token       n_b_tok;

    // this cell counts for the query only if it was filled before it
    assign n_hit = i_tok.valid && i_tok.has_result
                   && (nevs_pkg::CNT_W'(i_index) < i_tok.count);

    // both differences in parallel, pick the non-negative one
    assign n_dp = {i_tok.x[nevs_pkg::VALUE_W-1], i_tok.x}
                - {r_value[nevs_pkg::VALUE_W-1], r_value};
    assign n_dn = {r_value[nevs_pkg::VALUE_W-1], r_value}
                - {i_tok.x[nevs_pkg::VALUE_W-1], i_tok.x};
    assign n_d  = n_dp[nevs_pkg::VALUE_W] ? n_dn[nevs_pkg::VALUE_W-1:0]
                                          : n_dp[nevs_pkg::VALUE_W-1:0];

    // value write when the storing query passes this cell
    always_ff @(posedge i_clk) begin
        if (i_adv && i_tok.valid && i_tok.wr_en && (i_tok.wr_idx == i_index)) begin
            r_value <= i_tok.x;
        end
    end

    // distance stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_a_tok <= i_tok;
            r_a_d   <= n_d;
            r_a_v   <= r_value;
            r_a_hit <= n_hit;
        end
    end

    // nearer distance wins, then smaller value; earlier cell keeps ties
    assign n_take = r_a_hit
                    && (!r_a_tok.best_ok
                        || (r_a_d < r_a_tok.best_d)
                        || ((r_a_d == r_a_tok.best_d)
                            && ($signed(r_a_v) < $signed(r_a_tok.best_v))));

    always_comb begin
        n_b_tok = r_a_tok;
        if (n_take) begin
            n_b_tok.best_ok  = 1'b1;
            n_b_tok.best_d   = r_a_d;
            n_b_tok.best_v   = r_a_v;
            n_b_tok.best_pos = nevs_pkg::CNT_W'(i_index) + nevs_pkg::CNT_W'(1);
        end
    end

    // compare stage register, feeds the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_b_tok <= n_b_tok;
        end
    end

    assign o_tok = r_b_tok;

endmodule

/* rtl/core/nearest_earlier_value_search.sv */
// ---------------------------------------------------------------------------
// nearest_earlier_value_search: nearest earlier value of a sequence
// Each value is matched against the stored earlier values of its sequence (up to
// HISTORY_DEPTH) by a chain of history cells; the result gives distance and position
// ---------------------------------------------------------------------------
//  channel   dir   tdata (low bit up)                          tuser
//  s_axis    in    sample_value[31:0]                          starts_sequence
//  m_axis    out   nearest_distance[31:0], nearest_position    capacity_exceeded
//                  [42:32], zero fill [47:43]
//
//  one item accepted per cycle while no held result stalls the chain; a result
//  reaches the output register through the two register stages of each of the
//  HISTORY_DEPTH cells, distance then compare, the first one taking the item at
//  its accepting edge, and then the output register after the last cell
//  the first item of a sequence is stored and gives no transfer at the output
//  reset clears the fill count and the chain valid bits; cell contents are
//  not cleared, so no clearing pass is needed
//  a held result (tready low) freezes the whole chain and the input side
// ---------------------------------------------------------------------------
module nearest_earlier_value_search (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // sample_value[31:0]
    input  logic        i_s_axis_tuser,   // starts_sequence
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // nearest_distance[31:0], nearest_position[42:32]
    output logic        o_m_axis_tuser    // capacity_exceeded
);

    localparam nevs_pkg::t_cnt DEPTH_CNT = nevs_pkg::CNT_W'(nevs_pkg::HISTORY_DEPTH);

    logic             adv;
    logic             acc;
    logic             first;
    logic             full;
    nevs_pkg::t_cnt   r_count;
    nevs_pkg::t_cnt   n_count;
    nevs_pkg::t_token tok_in;
    nevs_pkg::t_token chain [nevs_pkg::HISTORY_DEPTH+1];

    logic             r_out_valid;
    nevs_pkg::t_value r_out_d;
    logic [nevs_pkg::POS_W-1:0] r_out_pos;
    logic             r_out_full;

    // chain moves whenever the output register can take its result
    assign adv             = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = adv;
    assign acc             = i_s_axis_tvalid && adv;

    // sequence bookkeeping
    assign first = i_s_axis_tuser || (r_count == '0);
    assign full  = !first && (r_count == DEPTH_CNT);

    always_comb begin
        tok_in            = '0;
        tok_in.valid      = acc;
        tok_in.has_result = !first;
        tok_in.full       = full;
        tok_in.wr_en      = !full;
        tok_in.wr_idx     = first ? '0 : r_count[nevs_pkg::IDX_W-1:0];
        tok_in.count      = r_count;
        tok_in.x          = i_s_axis_tdata;
    end

    always_comb begin
        n_count = r_count;
        if (acc) begin
            if (first) begin
                n_count = nevs_pkg::CNT_W'(1);
            end else if (!full) begin
                n_count = r_count + nevs_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // row of history cells
    assign chain[0] = tok_in;

    for (genvar k = 0; k < nevs_pkg::HISTORY_DEPTH; k++) begin : g_cell
        nevs_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (adv),
            .i_index (nevs_pkg::t_idx'(k)),
            .i_tok   (chain[k]),
            .o_tok   (chain[k+1])
        );
    end

    // output register, only queries with a result make a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= chain[nevs_pkg::HISTORY_DEPTH].valid
                           && chain[nevs_pkg::HISTORY_DEPTH].has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_d    <= chain[nevs_pkg::HISTORY_DEPTH].best_d;
            r_out_pos  <= nevs_pkg::POS_W'(chain[nevs_pkg::HISTORY_DEPTH].best_pos);
            r_out_full <= chain[nevs_pkg::HISTORY_DEPTH].full;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_out_pos, r_out_d};
    assign o_m_axis_tuser  = r_out_full;

    // fill count never passes the history depth
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("fill count above history depth");

    // a sequence start leaves exactly one stored value
    a_start_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_s_axis_tuser) |=> (r_count == nevs_pkg::CNT_W'(1)))
        else $error("sequence start did not reset the fill count");

    // a delivered result always names a real earlier position
    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_pos != '0))
        else $error("result without a chosen position");

    // an item taken at a full store leaves the count at depth
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && full) |=> (r_count == DEPTH_CNT))
        else $error("full store changed its fill count");

endmodule
